// ===== hw/rtl/line_follower_steering_macros.svh =====
// Assertion macros shared by the line follower steering checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LINE_FOLLOWER_STEERING_MACROS_SVH
`define LINE_FOLLOWER_STEERING_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfs: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfs: next-cycle check failed");

`endif

// ===== hw/rtl/lfs_pkg.sv =====
// Shared types and constants for the line follower steering block.
// No dependencies; lfs_steer, the top level and the checker import this package.
`default_nettype none

package lfs_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TOP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_BIAS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAL_DELTA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVR_TICKS  = 3'd4;

    // Register reset values.
    localparam logic [7:0]  RST_RIGHT_TOP  = 8'd255;
    localparam logic [7:0]  RST_SPEED_BIAS = 8'd30;
    localparam logic [7:0]  RST_BAL_DELTA  = 8'd50;
    localparam logic [7:0]  RST_SPIN_SPEED = 8'd150;
    localparam logic [15:0] RST_OVR_TICKS  = 16'd1000;

    // Fixed steering constants.
    localparam logic [7:0] RAMP_START   = 8'd40;
    localparam logic [7:0] RAMP_STEP    = 8'd10;
    localparam logic [7:0] SPEED_MAX    = 8'd255;
    localparam logic [7:0] BAL_SPEED    = 8'd50;
    localparam logic [7:0] STRONG_EXTRA = 8'd30;
    localparam logic [7:0] SPIN_OFFSET  = 8'd50;
    localparam logic [2:0] TURN_MIN_CNT = 3'd3;

    // Input item kinds carried on tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [2:0] {
        MODE_FOLLOW = 3'd0,
        MODE_BAL_L  = 3'd1,
        MODE_BAL_R  = 3'd2,
        MODE_OVR_R  = 3'd3,
        MODE_OVR_L  = 3'd4,
        MODE_SPIN_R = 3'd5,
        MODE_SPIN_L = 3'd6
    } mode_t;

    // Motor command: direction flag and speed magnitude.
    typedef struct packed {
        logic       rev;
        logic [7:0] speed;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  right_top;
        logic [7:0]  speed_bias;
        logic [7:0]  bal_delta;
        logic [7:0]  spin_speed;
        logic [15:0] ovr_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] ovr_count;
        logic [7:0]  ramp;
        cmd_t        left_cmd;
        cmd_t        right_cmd;
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfs_steer.sv =====
// Next-state logic of the steering controller: one item against current state.
// Depends on lfs_pkg for the state, configuration and mode types.
`default_nettype none

module lfs_steer (
    input  wire logic          op,
    input  wire logic [7:0]    sensor_bits,
    input  wire lfs_pkg::cfg_t cfg,
    input  wire lfs_pkg::state_t st,
    output lfs_pkg::state_t    nxt
);
    import lfs_pkg::*;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } turn_t;

    logic [2:0] left_cnt;
    logic [2:0] right_cnt;
    logic [7:0] left_top;
    turn_t      turn;
    logic       centre;

    // Subtraction floored at zero, on 9-bit operands.
    function automatic logic [7:0] sub_floor(input logic [8:0] a, input logic [8:0] b);
        logic [8:0] d;
        d = a - b;
        return (a > b) ? d[7:0] : 8'd0;
    endfunction

    function automatic state_t start_turn(input state_t s, input turn_t t,
                                          input cfg_t c, input logic [7:0] ltop);
        state_t r;
        r = s;
        r.left_cmd  = '{rev: 1'b0, speed: ltop};
        r.right_cmd = '{rev: 1'b0, speed: c.right_top};
        r.ovr_count = c.ovr_ticks;
        r.mode      = (t == TURN_LEFT) ? MODE_OVR_L : MODE_OVR_R;
        return r;
    endfunction

    // Full follow-mode decision in priority order.
    function automatic state_t follow_step(input state_t s, input logic [7:0] b,
                                           input logic [2:0] lc, input logic [2:0] rc,
                                           input turn_t t, input cfg_t c,
                                           input logic [7:0] ltop);
        state_t     r;
        logic [8:0] heavy_delta;
        r = s;
        heavy_delta = {1'b0, c.bal_delta} + {1'b0, STRONG_EXTRA};
        r.mode = MODE_FOLLOW;
        if (t != TURN_NONE) begin
            r = start_turn(s, t, c, ltop);
        end
        else if (!b[4] && b[3] && !b[2]) begin
            r.right_cmd = '{rev: 1'b0, speed: sub_floor({1'b0, c.right_top},
                                                          {1'b0, c.bal_delta})};
            r.left_cmd  = '{rev: 1'b0, speed: ltop};
        end
        else if (b[4] && !b[3] && !b[5]) begin
            r.right_cmd = '{rev: 1'b0, speed: c.right_top};
            r.left_cmd  = '{rev: 1'b0, speed: sub_floor({1'b0, ltop}, {1'b0, c.bal_delta})};
        end
        else if (!b[4] && b[3] && b[2]) begin
            r.right_cmd = '{rev: 1'b0, speed: sub_floor({1'b0, c.right_top}, heavy_delta)};
            r.left_cmd  = '{rev: 1'b0, speed: ltop};
        end
        else if (b[4] && !b[3] && b[5]) begin
            r.right_cmd = '{rev: 1'b0, speed: c.right_top};
            r.left_cmd  = '{rev: 1'b0, speed: sub_floor({1'b0, ltop}, heavy_delta)};
        end
        else if (lc != rc) begin
            if (lc > rc) begin
                r.left_cmd = '{rev: 1'b0, speed: BAL_SPEED};
            end
            else begin
                r.right_cmd = '{rev: 1'b0, speed: BAL_SPEED};
            end
            if (!b[3] && !b[4]) begin
                r.mode = (lc > rc) ? MODE_BAL_L : MODE_BAL_R;
                r.ramp = RAMP_START;
            end
        end
        else if (lc == 3'd0) begin
            r.left_cmd  = '{rev: 1'b0, speed: 8'd0};
            r.right_cmd = '{rev: 1'b0, speed: 8'd0};
        end
        else begin
            r.left_cmd  = '{rev: 1'b0, speed: ltop};
            r.right_cmd = '{rev: 1'b0, speed: c.right_top};
        end
        return r;
    endfunction

    // One ramp step while balancing.
    function automatic state_t balance_step(input state_t s, input logic ctr,
                                            input turn_t t, input cfg_t c,
                                            input logic [7:0] ltop);
        state_t     r;
        logic [8:0] sum;
        r = s;
        sum = {1'b0, s.ramp} + {1'b0, RAMP_STEP};
        if (t != TURN_NONE) begin
            r = start_turn(s, t, c, ltop);
        end
        else if (s.ramp == SPEED_MAX) begin
            r.mode = MODE_FOLLOW;
        end
        else begin
            r.ramp = (sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : sum[7:0];
            if (s.mode == MODE_BAL_L) begin
                r.left_cmd = '{rev: 1'b0, speed: r.ramp};
            end
            else begin
                r.right_cmd = '{rev: 1'b0, speed: r.ramp};
            end
            if (ctr) begin
                r.mode = MODE_FOLLOW;
            end
        end
        return r;
    endfunction

    // Spin pattern applied when the overshoot count runs out.
    function automatic state_t spin_step(input state_t s, input cfg_t c);
        state_t     r;
        logic [8:0] up;
        r = s;
        up = {1'b0, c.spin_speed} + {1'b0, SPIN_OFFSET};
        if (s.mode == MODE_OVR_R) begin
            r.right_cmd = '{rev: 1'b1, speed: c.spin_speed};
            r.left_cmd  = '{rev: 1'b0, speed: c.spin_speed};
            r.mode      = MODE_SPIN_R;
        end
        else begin
            r.right_cmd = '{rev: 1'b0, speed: sub_floor({1'b0, c.spin_speed},
                                                          {1'b0, SPIN_OFFSET})};
            r.left_cmd  = '{rev: 1'b1,
                            speed: (up > {1'b0, SPEED_MAX}) ? SPEED_MAX : up[7:0]};
            r.mode      = MODE_SPIN_L;
        end
        return r;
    endfunction

    // Half counts, turn test and centre detection.
    always_comb
    begin
        right_cnt = 3'({2'b0, sensor_bits[0]} + {2'b0, sensor_bits[1]}
                     + {2'b0, sensor_bits[2]} + {2'b0, sensor_bits[3]});
        left_cnt  = 3'({2'b0, sensor_bits[4]} + {2'b0, sensor_bits[5]}
                     + {2'b0, sensor_bits[6]} + {2'b0, sensor_bits[7]});
        left_top  = sub_floor({1'b0, cfg.right_top}, {1'b0, cfg.speed_bias});
        centre    = sensor_bits[3] | sensor_bits[4];
        if (left_cnt >= TURN_MIN_CNT && sensor_bits[7] && sensor_bits[6]) begin
            turn = TURN_LEFT;
        end
        else if (right_cnt >= TURN_MIN_CNT && sensor_bits[0] && sensor_bits[1]) begin
            turn = TURN_RIGHT;
        end
        else begin
            turn = TURN_NONE;
        end
    end

    // Mode dispatch.
    always_comb
    begin
        nxt = st;
        if (op == OP_TICK) begin
            if (st.mode == MODE_OVR_R || st.mode == MODE_OVR_L) begin
                if (st.ovr_count <= 16'd1) begin
                    nxt = spin_step(st, cfg);
                    nxt.ovr_count = 16'd0;
                end
                else begin
                    nxt.ovr_count = st.ovr_count - 16'd1;
                end
            end
        end
        else begin
            case (st.mode)
                MODE_FOLLOW:
                begin
                    nxt = follow_step(st, sensor_bits, left_cnt, right_cnt, turn, cfg, left_top);
                end
                MODE_BAL_L, MODE_BAL_R:
                begin
                    nxt = balance_step(st, centre, turn, cfg, left_top);
                end
                MODE_SPIN_R, MODE_SPIN_L:
                begin
                    if (centre) begin
                        nxt = follow_step(st, sensor_bits, left_cnt, right_cnt, turn, cfg,
                                          left_top);
                    end
                end
                default:
                begin
                    nxt = st;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/line_follower_steering.sv =====
// Top level of the line follower steering block: ports, registers, pipeline.
// Depends on lfs_pkg and lfs_steer.
//
//   Channel   Direction  Beat content
//   s_axis    in         tuser[0] op (0 sample, 1 tick); tdata[7:0] sensor_bits
//   m_axis    out        left/right speed and reverse, mode_now (see port comment)
//   cfg       in         write enable, register index, 16-bit write data
//
// An accepted beat is held in the input register, then its result is registered
// in the output register. One beat is taken every cycle while the result side
// is not stalled; the state is updated as each item leaves the input register.
// Reset clears configuration to its defaults, mode to follow and both commands
// to forward stopped. A stalled result holds its beat while the input register
// still accepts one more item; further input then waits.
`default_nettype none

module line_follower_steering (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] sensor_bits
    input  wire logic [0:0]                     s_tuser,   // [0] op
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] left_speed, [8] left_reverse, [16:9] right_speed, [17] right_reverse,
    // [20:18] mode_now, [23:21] zero
    output logic [23:0]                         m_tdata,
    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lfs_pkg::*;

    cfg_t        cfg_reg;
    state_t      state_reg;
    state_t      state_next;
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_bits_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_free;
    logic        advance;
    logic        in_take;

    // Handshake and stage advance.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    lfs_steer u_steer (
        .op          (in_op_reg),
        .sensor_bits (in_bits_reg),
        .cfg         (cfg_reg),
        .st          (state_reg),
        .nxt         (state_next)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right_top  <= RST_RIGHT_TOP;
            cfg_reg.speed_bias <= RST_SPEED_BIAS;
            cfg_reg.bal_delta  <= RST_BAL_DELTA;
            cfg_reg.spin_speed <= RST_SPIN_SPEED;
            cfg_reg.ovr_ticks  <= RST_OVR_TICKS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RIGHT_TOP:  cfg_reg.right_top  <= cfg_wdata[7:0];
                REG_SPEED_BIAS: cfg_reg.speed_bias <= cfg_wdata[7:0];
                REG_BAL_DELTA:  cfg_reg.bal_delta  <= cfg_wdata[7:0];
                REG_SPIN_SPEED: cfg_reg.spin_speed <= cfg_wdata[7:0];
                REG_OVR_TICKS:  cfg_reg.ovr_ticks  <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Steering state, updated once per item leaving the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= MODE_FOLLOW;
            state_reg.ovr_count <= 16'd0;
            state_reg.ramp      <= RAMP_START;
            state_reg.left_cmd  <= '0;
            state_reg.right_cmd <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_tuser[0];
            in_bits_reg <= s_tdata;
        end
    end

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {3'b000, 3'(state_next.mode),
                             state_next.right_cmd.rev, state_next.right_cmd.speed,
                             state_next.left_cmd.rev, state_next.left_cmd.speed};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfs_checker.sv =====
// Port-level checks for the line follower steering block, bound to the top level.
// Depends on lfs_pkg and line_follower_steering_macros.svh.
`default_nettype none

`include "line_follower_steering_macros.svh"

module lfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import lfs_pkg::*;

    logic [2:0] mode_o;
    logic       left_rev_o;
    logic       right_rev_o;
    logic [7:0] left_spd_o;
    logic [7:0] right_spd_o;

    assign mode_o      = m_tdata[20:18];
    assign left_rev_o  = m_tdata[8];
    assign right_rev_o = m_tdata[17];
    assign left_spd_o  = m_tdata[7:0];
    assign right_spd_o = m_tdata[16:9];

    // A stalled result beat keeps its payload.
    `LFS_ASSERT_NXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Spinning always drives exactly the matching wheel in reverse.
    `LFS_ASSERT_IMP(a_spin_dir, m_tvalid && (mode_o == MODE_SPIN_R || mode_o == MODE_SPIN_L),
                    (right_rev_o == (mode_o == MODE_SPIN_R)) && (left_rev_o != right_rev_o))

    // Overshoot drives both wheels forward.
    `LFS_ASSERT_IMP(a_ovr_fwd, m_tvalid && (mode_o == MODE_OVR_R || mode_o == MODE_OVR_L),
                    !left_rev_o && !right_rev_o)

    // A balancing wheel runs forward at no less than the balance speed.
    `LFS_ASSERT_IMP(a_bal_left, m_tvalid && mode_o == MODE_BAL_L,
                    !left_rev_o && left_spd_o >= BAL_SPEED)
    `LFS_ASSERT_IMP(a_bal_right, m_tvalid && mode_o == MODE_BAL_R,
                    !right_rev_o && right_spd_o >= BAL_SPEED)

endmodule

bind line_follower_steering lfs_checker u_lfs_checker (.*);

`default_nettype wire

// ===== tb/sv/line_follower_steering_test.sv =====
// Self-checking testbench for the line follower steering block: directed patterns,
// turn and balance sequences, back-pressure and randomised traffic, checked beat by beat.
// Depends on lfs_pkg and the line_follower_steering RTL; reads no files.
module line_follower_steering_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    localparam int IDLE_MAX       = 11;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int LONG_TICKS     = 60;

    typedef enum logic [1:0] {
        TURN_NONE,
        TURN_LEFT,
        TURN_RIGHT
    } turn_dir_t;

    // Expected content of one result beat.
    typedef struct packed {
        mode_t      mode;
        logic [8:0] left_cmd;
        logic [8:0] right_cmd;
    } steer_out_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted state of the block and its registers.
    cfg_t        cfg_model;
    mode_t       mode_model;
    logic [15:0] ovr_model;
    logic [8:0]  ramp_model;
    logic [8:0]  left_model;
    logic [8:0]  right_model;

    steer_out_t  steer_expected_q[$];
    int          error_count  = 0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    int          rx_hold      = 0;
    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;

    line_follower_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock, 4 ns period.
    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // Steering predictor
    // ---------------------------------------------------------------

    // Subtraction of speeds, floored at zero.
    function automatic logic [7:0] floor_sub(input logic [8:0] a, input logic [8:0] b);
        logic [8:0] diff;
        diff = (a > b) ? a - b : 9'd0;
        return diff[7:0];
    endfunction

    function automatic logic [7:0] left_cruise();
        return floor_sub({1'b0, cfg_model.right_top}, {1'b0, cfg_model.speed_bias});
    endfunction

    function automatic turn_dir_t turn_check(input logic [7:0] bits,
                                             input logic [2:0] lc, input logic [2:0] rc);
        if (lc >= TURN_MIN_CNT && bits[7] && bits[6])
            return TURN_LEFT;
        if (rc >= TURN_MIN_CNT && bits[0] && bits[1])
            return TURN_RIGHT;
        return TURN_NONE;
    endfunction

    // A turn drives straight at cruise speed and loads the overshoot counter.
    function automatic void begin_turn(input turn_dir_t dir);
        left_model  = {1'b0, left_cruise()};
        right_model = {1'b0, cfg_model.right_top};
        ovr_model   = cfg_model.ovr_ticks;
        mode_model  = (dir == TURN_LEFT) ? MODE_OVR_L : MODE_OVR_R;
    endfunction

    // Spin pattern once the overshoot has run out.
    function automatic void begin_spin();
        logic [8:0] spin_up;
        if (mode_model == MODE_OVR_R)
        begin
            right_model = {1'b1, cfg_model.spin_speed};
            left_model  = {1'b0, cfg_model.spin_speed};
            mode_model  = MODE_SPIN_R;
        end
        else
        begin
            spin_up = {1'b0, cfg_model.spin_speed} + {1'b0, SPIN_OFFSET};
            if (spin_up > {1'b0, SPEED_MAX})
                spin_up = {1'b0, SPEED_MAX};
            right_model = {1'b0, floor_sub({1'b0, cfg_model.spin_speed}, {1'b0, SPIN_OFFSET})};
            left_model  = {1'b1, spin_up[7:0]};
            mode_model  = MODE_SPIN_L;
        end
    endfunction

    // Full decision taken on a sample in follow mode.
    function automatic void follow_decide(input logic [7:0] bits,
                                          input logic [2:0] lc, input logic [2:0] rc);
        turn_dir_t  dir;
        logic [8:0] heavy_delta;
        dir         = turn_check(bits, lc, rc);
        heavy_delta = {1'b0, cfg_model.bal_delta} + {1'b0, STRONG_EXTRA};
        mode_model = MODE_FOLLOW;
        if (dir != TURN_NONE)
            begin_turn(dir);
        else if (!bits[4] && bits[3] && !bits[2])
        begin
            right_model = {1'b0, floor_sub({1'b0, cfg_model.right_top},
                                           {1'b0, cfg_model.bal_delta})};
            left_model  = {1'b0, left_cruise()};
        end
        else if (bits[4] && !bits[3] && !bits[5])
        begin
            right_model = {1'b0, cfg_model.right_top};
            left_model  = {1'b0, floor_sub({1'b0, left_cruise()}, {1'b0, cfg_model.bal_delta})};
        end
        else if (!bits[4] && bits[3] && bits[2])
        begin
            right_model = {1'b0, floor_sub({1'b0, cfg_model.right_top}, heavy_delta)};
            left_model  = {1'b0, left_cruise()};
        end
        else if (bits[4] && !bits[3] && bits[5])
        begin
            right_model = {1'b0, cfg_model.right_top};
            left_model  = {1'b0, floor_sub({1'b0, left_cruise()}, heavy_delta)};
        end
        else if (lc != rc)
        begin
            if (lc > rc)
                left_model = {1'b0, BAL_SPEED};
            else
                right_model = {1'b0, BAL_SPEED};
            if (!bits[3] && !bits[4])
            begin
                mode_model = (lc > rc) ? MODE_BAL_L : MODE_BAL_R;
                ramp_model = {1'b0, RAMP_START};
            end
        end
        else if (lc == 3'd0)
        begin
            left_model  = '0;
            right_model = '0;
        end
        else
        begin
            left_model  = {1'b0, left_cruise()};
            right_model = {1'b0, cfg_model.right_top};
        end
    endfunction

    // One sample while ramping a wheel back onto the line.
    function automatic void balance_step(input logic [7:0] bits,
                                         input logic [2:0] lc, input logic [2:0] rc);
        turn_dir_t dir;
        dir = turn_check(bits, lc, rc);
        if (dir != TURN_NONE)
        begin
            begin_turn(dir);
            return;
        end
        if (ramp_model >= {1'b0, SPEED_MAX})
        begin
            mode_model = MODE_FOLLOW;
            return;
        end
        ramp_model = ramp_model + {1'b0, RAMP_STEP};
        if (ramp_model > {1'b0, SPEED_MAX})
            ramp_model = {1'b0, SPEED_MAX};
        if (mode_model == MODE_BAL_L)
            left_model = {1'b0, ramp_model[7:0]};
        else
            right_model = {1'b0, ramp_model[7:0]};
        if (bits[3] || bits[4])
            mode_model = MODE_FOLLOW;
    endfunction

    // Advances the predicted state by one accepted beat and returns the expected result.
    function automatic steer_out_t steer_predict(input logic op, input logic [7:0] bits);
        logic [2:0] lc;
        logic [2:0] rc;
        steer_out_t res;
        lc = 3'($countones(bits[7:4]));
        rc = 3'($countones(bits[3:0]));
        if (op == OP_TICK)
        begin
            if (mode_model == MODE_OVR_R || mode_model == MODE_OVR_L)
            begin
                if (ovr_model != 16'd0)
                    ovr_model = ovr_model - 16'd1;
                if (ovr_model == 16'd0)
                    begin_spin();
            end
        end
        else
        begin
            case (mode_model)
                MODE_FOLLOW:
                    follow_decide(bits, lc, rc);
                MODE_BAL_L, MODE_BAL_R:
                    balance_step(bits, lc, rc);
                MODE_SPIN_R, MODE_SPIN_L:
                    if (bits[3] || bits[4])
                        follow_decide(bits, lc, rc);
                default:
                    ;
            endcase
        end
        res.mode      = mode_model;
        res.left_cmd  = left_model;
        res.right_cmd = right_model;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Shared stimulus helpers
    // ---------------------------------------------------------------

    // Offers one beat after a random gap and records its prediction on acceptance.
    task automatic send_item(input logic op, input logic [7:0] bits);
        int gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bits;
        do @(posedge clk); while (!s_tready);
        steer_expected_q.push_back(steer_predict(op, bits));
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (steer_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Writes all five registers once the block has gone quiet.
    task automatic write_config(input logic [7:0] right_top, input logic [7:0] bias,
                                input logic [7:0] delta, input logic [7:0] spin,
                                input logic [15:0] ticks);
        drain_pipe();
        cfg_beat(REG_RIGHT_TOP,  {8'd0, right_top});
        cfg_beat(REG_SPEED_BIAS, {8'd0, bias});
        cfg_beat(REG_BAL_DELTA,  {8'd0, delta});
        cfg_beat(REG_SPIN_SPEED, {8'd0, spin});
        cfg_beat(REG_OVR_TICKS,  ticks);
        cfg_wr_en <= 1'b0;
        cfg_model = {right_top, bias, delta, spin, ticks};
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Centering patterns, stop and cruise with the registers at their reset values.
    task automatic test_follow_patterns();
        logic [7:0] pats [7] = '{8'h08, 8'h10, 8'h0C, 8'h30, 8'h18, 8'h00, 8'h42};
        foreach (pats[i])
            send_item(OP_SAMPLE, pats[i]);
    endtask

    // Balance entry on both sides, a ramp step, an ignored tick and the centre exit.
    task automatic test_balance_ramp();
        send_item(OP_SAMPLE, 8'h38);
        send_item(OP_SAMPLE, 8'h60);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_TICK,   8'hFF);
        send_item(OP_SAMPLE, 8'h08);
        send_item(OP_SAMPLE, 8'h06);
        send_item(OP_SAMPLE, 8'h81);
        send_item(OP_SAMPLE, 8'h10);
    endtask

    // Both turns, a turn out of balance, and a zero overshoot with extreme spin speeds.
    task automatic test_turns();
        write_config(8'd255, 8'd30, 8'd50, 8'd205, 16'd2);
        send_item(OP_SAMPLE, 8'hE0);
        send_item(OP_SAMPLE, 8'h18);
        send_item(OP_TICK,   8'h00);
        send_item(OP_TICK,   8'h00);
        send_item(OP_SAMPLE, 8'h01);
        send_item(OP_SAMPLE, 8'h10);
        send_item(OP_SAMPLE, 8'h06);
        send_item(OP_SAMPLE, 8'h07);
        send_item(OP_TICK,   8'h00);
        send_item(OP_TICK,   8'h00);
        send_item(OP_SAMPLE, 8'h08);

        write_config(8'd255, 8'd30, 8'd50, 8'd50, 16'd0);
        send_item(OP_SAMPLE, 8'h0B);
        send_item(OP_TICK,   8'h00);
        send_item(OP_SAMPLE, 8'hE0);
        send_item(OP_SAMPLE, 8'h08);
        send_item(OP_SAMPLE, 8'hF0);
        send_item(OP_TICK,   8'h00);
        send_item(OP_SAMPLE, 8'h18);
    endtask

    // A long overshoot counted down in full, back to back.
    task automatic test_long_overshoot();
        logic [7:0] noise;
        write_config(8'd255, 8'd30, 8'd50, 8'd150, 16'(LONG_TICKS));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_item(OP_SAMPLE, 8'hD0);
        for (int i = 0; i < LONG_TICKS; i++)
        begin
            noise = 8'($urandom_range(0, 255));
            send_item(OP_TICK, noise);
        end
        send_item(OP_SAMPLE, 8'h08);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        logic [7:0] noise;
        write_config(8'd200, 8'd20, 8'd40, 8'd120, 16'd3);
        tx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
        begin
            noise = 8'($urandom_range(0, 255));
            send_item(logic'($urandom_range(0, 1)), noise);
        end
        tx_idle = 1'b1;
    endtask

    // Mostly well-formed turn and balance sequences with random content, plus noise.
    task automatic test_random_sequences();
        int         kind;
        int         count;
        int         target;
        logic [7:0] bits;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: write_config(8'd0, 8'd255, 8'd200, 8'd50, 16'd0);
                1: write_config(8'd255, 8'd0, 8'd0, 8'd205, 16'd12);
                2: write_config(8'd100, 8'd100, 8'd200, 8'd205, 16'd1);
                default:
                    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 200)), 8'($urandom_range(50, 205)),
                                 16'($urandom_range(0, 12)));
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            target  = items_sent + 100;
            while (items_sent < target)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 3)
                begin
                    // Turn: trigger sample, overshoot ticks with stray samples, spin, exit.
                    bits = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1))
                    begin
                        bits[7:6] = 2'b11;
                        if (bits[5:4] == 2'b00)
                            bits[4 + $urandom_range(0, 1)] = 1'b1;
                    end
                    else
                    begin
                        bits[1:0] = 2'b11;
                        if (bits[3:2] == 2'b00)
                            bits[2 + $urandom_range(0, 1)] = 1'b1;
                    end
                    send_item(OP_SAMPLE, bits);
                    count = cfg_model.ovr_ticks + $urandom_range(0, 3);
                    for (int i = 0; i < count; i++)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 3) == 0)
                            send_item(OP_SAMPLE, bits);
                        send_item(OP_TICK, bits);
                    end
                    count = $urandom_range(0, 3);
                    for (int i = 0; i < count; i++)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        send_item(OP_SAMPLE, bits & 8'hE7);
                    end
                    if ($urandom_range(0, 7) != 0)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        bits[3 + $urandom_range(0, 1)] = 1'b1;
                        send_item(OP_SAMPLE, bits);
                    end
                end
                else if (kind < 6)
                begin
                    // Balance: off-centre entry, a ramp of varying length, centre exit.
                    bits = 8'($urandom_range(0, 255));
                    bits = bits & 8'hE7;
                    if ($countones(bits[7:4]) == $countones(bits[3:0]))
                        bits[0] = ~bits[0];
                    send_item(OP_SAMPLE, bits);
                    count = $urandom_range(0, 27);
                    for (int i = 0; i < count; i++)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        bits = bits & (($urandom_range(0, 7) == 0) ? 8'hE7 : 8'h66);
                        send_item(($urandom_range(0, 9) == 0) ? OP_TICK : OP_SAMPLE, bits);
                    end
                    if ($urandom_range(0, 7) != 0)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        bits[3 + $urandom_range(0, 1)] = 1'b1;
                        send_item(OP_SAMPLE, bits);
                    end
                end
                else
                begin
                    // Noise: any kind, any sensor pattern.
                    count = $urandom_range(1, 6);
                    for (int i = 0; i < count; i++)
                    begin
                        bits = 8'($urandom_range(0, 255));
                        send_item(logic'($urandom_range(0, 1)), bits);
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result beats: random ready, long hold-off on request, field checks
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int         gap;
        steer_out_t want;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (steer_expected_q.size() == 0)
            begin
                $display("%0t ns: unexpected result beat: expected none actual %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = steer_expected_q.pop_front();
                compare_field("left_speed",    want.left_cmd[7:0],  m_tdata[7:0]);
                compare_field("left_reverse",  {7'd0, want.left_cmd[8]},  {7'd0, m_tdata[8]});
                compare_field("right_speed",   want.right_cmd[7:0], m_tdata[16:9]);
                compare_field("right_reverse", {7'd0, want.right_cmd[8]}, {7'd0, m_tdata[17]});
                compare_field("mode_now",      {5'd0, want.mode},   {5'd0, m_tdata[20:18]});
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** line_follower_steering: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset once, then every test in turn.
    initial
    begin : stimulus
        cfg_model   = {RST_RIGHT_TOP, RST_SPEED_BIAS, RST_BAL_DELTA, RST_SPIN_SPEED,
                       RST_OVR_TICKS};
        mode_model  = MODE_FOLLOW;
        ovr_model   = '0;
        ramp_model  = {1'b0, RAMP_START};
        left_model  = '0;
        right_model = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_follow_patterns();
        test_balance_ramp();
        test_turns();
        test_long_overshoot();
        test_backpressure();
        test_random_sequences();
        drain_pipe();
        if (error_count == 0)
            $display("** line_follower_steering: PASSED **");
        else
            $display("** line_follower_steering: FAILED **");
        $finish;
    end

endmodule
